// File: sv/imu_yaw_tilt_estimator_macros.svh
// Assertion macros for the IMU yaw and tilt estimator.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef IMU_YAW_TILT_ESTIMATOR_MACROS_SVH
`define IMU_YAW_TILT_ESTIMATOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define IYT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("iyt: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define IYT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("iyt: next-cycle check failed");

`endif

// File: sv/iyt_pkg.sv
// Shared constants, types and CORDIC helpers of the IMU yaw and tilt estimator.
// No dependencies; every other file but the macro header imports it.
`default_nettype none

package iyt_pkg;

    localparam int CALIB_SAMPLES = 500;
    localparam int CORDIC_STEPS  = 16;

    localparam int DB_W          = 15;
    localparam logic [DB_W-1:0] DEADBAND_RST = 15'd61;
    localparam int CNT_W         = 13;
    localparam int BSUM_W        = 28;

    localparam logic [16:0] YAW_K    = 17'd120158;
    localparam logic [15:0] INV_GAIN = 16'd39797;

    // CORDIC datapath widths: x/y carry inputs scaled by 256 plus gain growth
    localparam int CW     = 28;
    localparam int ZW     = 27;
    localparam int STEP_W = 5;
    localparam int TAB_N  = 24;

    // Reciprocal of the calibration length for the bias mean
    localparam int REC_SH = 37;
    localparam longint unsigned REC =
        ((64'd1 << REC_SH) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
    localparam int REC_W  = $clog2(REC + 1);
    localparam int CALX_W = 28;
    localparam int QE_W   = 17;

    localparam logic signed [ZW-1:0] Z_HALF = ZW'(180 * 65536);

    localparam logic signed [ZW-1:0] ATAN_TAB [TAB_N] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379,
        27'sd117266, 27'sd58666, 27'sd29335, 27'sd14668, 27'sd7334,
        27'sd3667, 27'sd1833, 27'sd917, 27'sd458, 27'sd229, 27'sd115,
        27'sd57, 27'sd29, 27'sd14, 27'sd7, 27'sd4, 27'sd2, 27'sd1, 27'sd0
    };

    typedef enum logic [1:0] {
        CMD_CALIB     = 2'd0,
        CMD_UPDATE    = 2'd1,
        CMD_YAW_RESET = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_U_P,
        S_U_LO,
        S_U_HI,
        S_U_ACC,
        S_ROLL_WAIT,
        S_MAG,
        S_PITCH_GO,
        S_PITCH_WAIT,
        S_CAL_MUL,
        S_CAL_FIX,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                 v;
        logic                 zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic_beat;

    function automatic logic signed [ZW-1:0] atan_at(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] a;
        a = '0;
        if (i < STEP_W'(TAB_N)) begin
            a = ATAN_TAB[i];
        end
        return a;
    endfunction

    // Fold the left half-plane onto the right and flag the zero vector
    function automatic t_cordic_beat cordic_pre(input logic signed [CW-1:0] x,
                                               input logic signed [CW-1:0] y);
        t_cordic_beat b;
        b.v    = 1'b1;
        b.zero = (x == '0) && (y == '0);
        b.x    = x;
        b.y    = y;
        b.z    = '0;
        if (x < 0) begin
            b.z = (y >= 0) ? Z_HALF : -Z_HALF;
            b.x = -x;
            b.y = -y;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// File: sv/iyt_ifs.sv
// Channel interfaces of the IMU yaw and tilt estimator: sample in, result out, config.
// Depends on iyt_pkg for the deadband width.
`default_nettype none

interface iyt_sample_if import iyt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [31:0]        timestamp_ms;
    logic signed [15:0] gyro_rate;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (output valid, command, timestamp_ms, gyro_rate, accel_x, accel_y,
                    accel_z, input ready);
    modport sink   (input valid, command, timestamp_ms, gyro_rate, accel_x, accel_y,
                    accel_z, output ready);
endinterface

interface iyt_result_if import iyt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [31:0] yaw_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic               calibrating;
    logic               yaw_saturated;

    modport source (output valid, yaw_angle, pitch_angle, roll_angle, calibrating,
                    yaw_saturated, input ready);
    modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, calibrating,
                    yaw_saturated, output ready);
endinterface

interface iyt_cfg_if import iyt_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [DB_W-1:0] deadband;

    modport source (output valid, deadband, input ready);
    modport sink   (input valid, deadband, output ready);
endinterface

`default_nettype wire

// File: sv/iyt_cordic_cell.sv
// One vectoring CORDIC micro-rotation, registered; its step index comes in as a port.
// Depends on iyt_pkg for the beat type and arctangent table.
`default_nettype none

module iyt_cordic_cell import iyt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [STEP_W-1:0] i_step,
    input  wire t_cordic_beat      i_d,
    output t_cordic_beat           o_d
);

    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    t_cordic_beat         n_d;
    t_cordic_beat         r_d;

    // Rotate towards the x axis by the step's angle
    always_comb begin
        w_xs = i_d.x >>> i_step;
        w_ys = i_d.y >>> i_step;
        n_d  = i_d;
        if (i_d.y > 0) begin
            n_d.x = i_d.x + w_ys;
            n_d.y = i_d.y - w_xs;
            n_d.z = i_d.z + atan_at(i_step);
        end else begin
            n_d.x = i_d.x - w_ys;
            n_d.y = i_d.y + w_xs;
            n_d.z = i_d.z - atan_at(i_step);
        end
    end

    // Hand the beat on; reset drops only the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.v <= 1'b0;
        end else begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

// File: sv/iyt_cordic_chain.sv
// Row of CORDIC_STEPS cordic cells, one beat per cycle moving down the row.
// Depends on iyt_pkg and iyt_cordic_cell.
`default_nettype none

module iyt_cordic_chain import iyt_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cordic_beat i_d,
    output t_cordic_beat      o_d
);

    t_cordic_beat w_link [CORDIC_STEPS+1];

    assign w_link[0] = i_d;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        iyt_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_step (STEP_W'(g)),
            .i_d    (w_link[g]),
            .o_d    (w_link[g+1])
        );
    end

    assign o_d = w_link[CORDIC_STEPS];

endmodule

`default_nettype wire

// File: sv/imu_yaw_tilt_estimator.sv
// IMU yaw and tilt estimator: sequencer, yaw integrator, bias mean and output register.
// Depends on iyt_pkg, iyt_ifs, iyt_cordic_chain and the assertion macro header.
//
// Use: samples arrive on i_sample (valid/ready); one result per accepted transaction
// leaves on o_result (valid/ready). The deadband register is written on i_cfg, which
// is always ready; write it only while the block is idle.
// Sequence: an update sample steps through the yaw product states, then makes two
// passes through the CORDIC cell row (roll, then pitch from the roll magnitude) before
// its result is ready. A calibration sample goes straight to the done state, or through
// the bias mean states when it closes a run; a yaw reset or unused command goes straight
// to done. One sample is worked on at a time.
// i_sample.ready is high only while the sequencer idles.
// The result sits in an output register: the next sample is taken while it waits,
// and a finished result is held back until the register frees, so a stalled
// receiver stalls the sequencer, never drops data.
// Reset (synchronous, active low) clears yaw, holds, bias, calibration counters,
// the sequencer and the output valid, and loads the deadband with 61.
`default_nettype none
`include "imu_yaw_tilt_estimator_macros.svh"

module imu_yaw_tilt_estimator import iyt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    iyt_sample_if.sink    i_sample,
    iyt_cfg_if.sink       i_cfg,
    iyt_result_if.source  o_result
);

    localparam logic signed [43:0] YAW_MAX = 44'sd2147483647;
    localparam logic signed [43:0] YAW_MIN = -44'sd2147483648;
    localparam logic [48:0] P_LIM = 49'd1 << 40;

    t_state r_state;
    t_state n_state;

    logic [DB_W-1:0]          r_deadband;
    logic signed [31:0]       r_yaw;
    logic signed [14:0]       r_pitch;
    logic signed [15:0]       r_roll;
    logic [31:0]              r_prev;
    logic signed [15:0]       r_bias;
    logic signed [BSUM_W-1:0] r_bsum;
    logic [CNT_W-1:0]         r_cnt;

    logic [16:0]  r_gm;
    logic         r_neg;
    logic [31:0]  r_dt;
    logic [40:0]  r_p;
    logic [40:0]  r_plo;
    logic [57:0]  r_prod;
    logic         r_sat;
    logic signed [15:0] r_ax;

    logic [CALX_W-1:0] r_calx;
    logic              r_cneg;
    logic [QE_W-1:0]   r_qe;

    logic [ZW-1:0] r_mag;
    logic [ZW-1:0] r_mk;

    logic               r_ov;
    logic signed [31:0] r_out_yaw;
    logic signed [14:0] r_out_pitch;
    logic signed [15:0] r_out_roll;
    logic               r_out_cal;
    logic               r_out_sat;

    logic w_accept;
    logic w_load_out;
    logic w_in_ready;
    logic w_chain_go;

    logic [CNT_W-1:0]         w_cnt_inc;
    logic signed [BSUM_W-1:0] w_bsum_inc;
    logic                     w_cal_done;
    logic signed [16:0]       w_gz;
    logic [16:0]              w_gm;
    logic [48:0]              w_pfull;
    logic [33:0]              w_phi;
    logic [41:0]              w_inc;
    logic signed [43:0]       w_sum;
    logic [CALX_W+REC_W-1:0]  w_qprod;
    logic [QE_W+CNT_W-1:0]    w_qchk;
    logic [QE_W-1:0]          w_q;
    logic [42:0]              w_mkfull;
    logic signed [CW-1:0]     w_roll_x;
    logic signed [CW-1:0]     w_roll_y;
    logic signed [CW-1:0]     w_pitch_y;

    t_cordic_beat w_chain_in;
    t_cordic_beat w_chain_out;

    // Round a CORDIC angle to 1/128 degree and clamp it
    function automatic logic signed [15:0] to_deg(input logic signed [ZW-1:0] z,
                                                 input logic signed [15:0] lim);
        logic signed [ZW:0]   t;
        logic signed [ZW-9:0] s;
        logic signed [ZW-9:0] l;
        t = {z[ZW-1], z} + (ZW+1)'(256);
        s = t[ZW:9];
        l = (ZW-8)'(lim);
        if (s > l) begin
            s = l;
        end else if (s < -l) begin
            s = -l;
        end
        return 16'(s);
    endfunction

    assign w_accept   = i_sample.valid && i_sample.ready;
    assign i_cfg.ready = 1'b1;

    // Calibration bookkeeping for the incoming sample
    assign w_cnt_inc  = r_cnt + CNT_W'(1);
    assign w_bsum_inc = r_bsum + BSUM_W'(i_sample.gyro_rate);
    assign w_cal_done = w_cnt_inc >= CNT_W'(CALIB_SAMPLES);

    // Bias-corrected rate, magnitude and deadband
    always_comb begin
        w_gz = 17'(i_sample.gyro_rate) - 17'(r_bias);
        w_gm = w_gz[16] ? 17'(-w_gz) : 17'(w_gz);
        if (w_gm < {2'b00, r_deadband}) begin
            w_gm = '0;
        end
    end

    // Yaw increment datapath
    assign w_pfull = 49'(r_gm) * 49'(r_dt);
    assign w_phi   = 34'(r_p[40:24]) * 34'(YAW_K);
    assign w_inc   = 42'((r_prod + 58'd32768) >> 16);
    assign w_sum   = 44'(r_yaw) + (r_neg ? -$signed({2'b00, w_inc})
                                         : $signed({2'b00, w_inc}));

    // Bias mean: reciprocal estimate, then one correction
    assign w_qprod = (CALX_W+REC_W)'(r_calx) * (CALX_W+REC_W)'(REC);
    assign w_qchk  = (QE_W+CNT_W)'(r_qe) * (QE_W+CNT_W)'(CALIB_SAMPLES);
    assign w_q     = (w_qchk > (QE_W+CNT_W)'(r_calx)) ? r_qe - QE_W'(1) : r_qe;

    // Magnitude gain correction
    assign w_mkfull = 43'(r_mag) * 43'(INV_GAIN) + 43'd32768;

    // CORDIC operands scaled by 256
    assign w_roll_x  = $signed({{(CW-24){i_sample.accel_z[15]}}, i_sample.accel_z, 8'h00});
    assign w_roll_y  = -$signed({{(CW-24){i_sample.accel_y[15]}}, i_sample.accel_y, 8'h00});
    assign w_pitch_y = $signed({{(CW-24){r_ax[15]}}, r_ax, 8'h00});

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority case (i_sample.command)
                        CMD_CALIB:  n_state = w_cal_done ? S_CAL_MUL : S_DONE;
                        CMD_UPDATE: n_state = S_U_P;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_U_P:        n_state = S_U_LO;
            S_U_LO:       n_state = S_U_HI;
            S_U_HI:       n_state = S_U_ACC;
            S_U_ACC:      n_state = S_ROLL_WAIT;
            S_ROLL_WAIT:  n_state = w_chain_out.v ? S_MAG : S_ROLL_WAIT;
            S_MAG:        n_state = S_PITCH_GO;
            S_PITCH_GO:   n_state = S_PITCH_WAIT;
            S_PITCH_WAIT: n_state = w_chain_out.v ? S_DONE : S_PITCH_WAIT;
            S_CAL_MUL:    n_state = S_CAL_FIX;
            S_CAL_FIX:    n_state = S_DONE;
            S_DONE:       n_state = w_load_out ? S_IDLE : S_DONE;
            default:      n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_load_out = 1'b0;
        w_chain_go = 1'b0;
        unique case (r_state)
            S_IDLE:     w_in_ready = 1'b1;
            S_PITCH_GO: w_chain_go = 1'b1;
            S_DONE:     w_load_out = !r_ov || o_result.ready;
            default:    w_in_ready = 1'b0;
        endcase
    end

    assign i_sample.ready = w_in_ready;

    // Feed the cell row: roll on an accepted update, pitch after the magnitude
    always_comb begin
        if (w_chain_go) begin
            w_chain_in = cordic_pre($signed({1'b0, r_mk}), w_pitch_y);
        end else begin
            w_chain_in   = cordic_pre(w_roll_x, w_roll_y);
            w_chain_in.v = w_accept && (i_sample.command == CMD_UPDATE);
        end
    end

    iyt_cordic_chain u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_d    (w_chain_in),
        .o_d    (w_chain_out)
    );

    // Hold the state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= DEADBAND_RST;
        end else if (i_cfg.valid) begin
            r_deadband <= i_cfg.deadband;
        end
    end

    // Estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw   <= '0;
            r_pitch <= '0;
            r_roll  <= '0;
            r_prev  <= '0;
            r_bias  <= '0;
            r_bsum  <= '0;
            r_cnt   <= '0;
            r_sat   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_sat <= 1'b0;
                        priority case (i_sample.command)
                            CMD_CALIB: begin
                                r_prev <= i_sample.timestamp_ms;
                                if (w_cal_done) begin
                                    r_bsum <= '0;
                                    r_cnt  <= '0;
                                end else begin
                                    r_bsum <= w_bsum_inc;
                                    r_cnt  <= w_cnt_inc;
                                end
                            end
                            CMD_UPDATE: begin
                                r_prev <= i_sample.timestamp_ms;
                            end
                            CMD_YAW_RESET: begin
                                r_yaw <= '0;
                            end
                            default: begin
                                r_sat <= 1'b0;
                            end
                        endcase
                    end
                end
                S_U_ACC: begin
                    if (w_sum > YAW_MAX) begin
                        r_yaw <= 32'(YAW_MAX);
                        r_sat <= 1'b1;
                    end else if (w_sum < YAW_MIN) begin
                        r_yaw <= 32'(YAW_MIN);
                        r_sat <= 1'b1;
                    end else begin
                        r_yaw <= 32'(w_sum);
                    end
                end
                // A zero vector has angle zero
                S_ROLL_WAIT: begin
                    if (w_chain_out.v) begin
                        r_roll <= w_chain_out.zero ? '0
                                                   : to_deg(w_chain_out.z, 16'sd23040);
                    end
                end
                S_PITCH_WAIT: begin
                    if (w_chain_out.v) begin
                        r_pitch <= w_chain_out.zero ? '0
                                                    : 15'(to_deg(w_chain_out.z, 16'sd11520));
                    end
                end
                S_CAL_FIX: begin
                    r_bias <= r_cneg ? -$signed(16'(w_q)) : $signed(16'(w_q));
                    r_yaw  <= '0;
                end
                default: begin
                    r_sat <= r_sat;
                end
            endcase
        end
    end

    // Working registers of the yaw, bias and magnitude paths
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_gm   <= w_gm;
            r_neg  <= w_gz[16];
            r_dt   <= i_sample.timestamp_ms - r_prev;
            r_ax   <= i_sample.accel_x;
            r_calx <= (w_bsum_inc < 0 ? CALX_W'(-w_bsum_inc) : CALX_W'(w_bsum_inc))
                      + CALX_W'(CALIB_SAMPLES / 2);
            r_cneg <= w_bsum_inc < 0;
        end
        if (r_state == S_U_P) begin
            r_p <= (w_pfull > P_LIM) ? 41'(P_LIM) : 41'(w_pfull);
        end
        if (r_state == S_U_LO) begin
            r_plo <= 41'(r_p[23:0]) * 41'(YAW_K);
        end
        if (r_state == S_U_HI) begin
            r_prod <= {w_phi, 24'h000000} + 58'(r_plo);
        end
        if (r_state == S_CAL_MUL) begin
            r_qe <= w_qprod[REC_SH +: QE_W];
        end
        if (r_state == S_ROLL_WAIT && w_chain_out.v) begin
            r_mag <= w_chain_out.zero ? '0 : ZW'(w_chain_out.x);
        end
        if (r_state == S_MAG) begin
            r_mk <= w_mkfull[16 +: ZW];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_out) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_yaw   <= r_yaw;
            r_out_pitch <= r_pitch;
            r_out_roll  <= r_roll;
            r_out_cal   <= r_cnt != '0;
            r_out_sat   <= r_sat;
        end
    end

    assign o_result.valid         = r_ov;
    assign o_result.yaw_angle     = r_out_yaw;
    assign o_result.pitch_angle   = r_out_pitch;
    assign o_result.roll_angle    = r_out_roll;
    assign o_result.calibrating   = r_out_cal;
    assign o_result.yaw_saturated = r_out_sat;

    // Checks
    `IYT_ASSERT_NXT(a_busy_after_accept, i_sample.valid && i_sample.ready, !i_sample.ready)
    `IYT_ASSERT_IMP(a_sat_at_limit, o_result.valid && o_result.yaw_saturated, (o_result.yaw_angle == 32'(YAW_MAX) || o_result.yaw_angle == 32'(YAW_MIN)))
    `IYT_ASSERT_IMP(a_chain_expected, w_chain_out.v, (r_state == S_ROLL_WAIT || r_state == S_PITCH_WAIT))

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for the IMU yaw and tilt estimator: random and directed samples, scoreboard check.
// Depends on iyt_pkg, iyt_ifs and the estimator RTL.
`default_nettype none

module tb_top;
    import iyt_pkg::*;

    typedef struct packed {
        logic [31:0] yaw;
        logic [14:0] pitch;
        logic [15:0] roll;
        logic        calib;
        logic        sat;
    } t_attitude;

    // Scoreboard: tracks estimator state and queues expected attitude results
    class attitude_board;
        t_attitude   pending[$];
        int          mismatches;
        int          checked;
        logic [14:0] db;
        longint      yaw_acc, pitch_h, roll_h, bias, bsum;
        logic [31:0] prev_ts;
        int          bcount;

        function void clear();
            db = DEADBAND_RST; yaw_acc = 0; pitch_h = 0; roll_h = 0;
            bias = 0; bsum = 0; prev_ts = 0; bcount = 0;
        endfunction

        function longint floor_shift(longint v, int s);
            if (v >= 0) return v >>> s;
            return -(((-v) - 1) >>> s) - 1;
        endfunction

        function longint vector_angle(longint x, longint y, output longint mag);
            longint z, xs, ys;
            longint tab[24];
            tab = '{2949120, 1740967, 919879, 466945, 234379, 117266, 58666, 29335,
                    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
            z = 0;
            if (x == 0 && y == 0) begin
                mag = 0;
                return 0;
            end
            if (x < 0) begin
                z = (y >= 0) ? 180 * 65536 : -180 * 65536;
                x = -x; y = -y;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = floor_shift(x, i); ys = floor_shift(y, i);
                if (y > 0) begin
                    x += ys; y -= xs; z += tab[i];
                end else begin
                    x -= ys; y += xs; z -= tab[i];
                end
            end
            mag = x;
            return z;
        endfunction

        function longint to_deg(longint z, longint lim);
            longint v;
            v = floor_shift(z + 256, 9);
            return v < -lim ? -lim : (v > lim ? lim : v);
        endfunction

        function void note_sample(logic [1:0] cmd, logic [31:0] ts, logic signed [15:0] g,
                                  logic signed [15:0] ax, logic signed [15:0] ay,
                                  logic signed [15:0] az);
            t_attitude   r;
            longint      gz, m, q, sum, mag, mk;
            longint unsigned gm, p, inc;
            logic [31:0] dt;
            r.sat = 1'b0;
            if (cmd == CMD_CALIB) begin
                bsum += g; bcount++; prev_ts = ts;
                if (bcount >= CALIB_SAMPLES) begin
                    m = bsum < 0 ? -bsum : bsum;
                    q = (m + CALIB_SAMPLES / 2) / CALIB_SAMPLES;
                    bias = bsum < 0 ? -q : q;
                    bsum = 0; bcount = 0; yaw_acc = 0;
                end
            end else if (cmd == CMD_UPDATE) begin
                dt = ts - prev_ts;
                prev_ts = ts;
                gz = longint'(g) - bias;
                gm = gz < 0 ? -gz : gz;
                if (gm < db) gm = 0;
                p = gm * dt;
                if (p > (64'd1 << 40)) p = 64'd1 << 40;
                inc = (p * 120158 + 32768) >> 16;
                sum = yaw_acc + (gz < 0 ? -longint'(inc) : longint'(inc));
                if (sum > 64'sd2147483647) begin
                    sum = 64'sd2147483647; r.sat = 1'b1;
                end else if (sum < -64'sd2147483648) begin
                    sum = -64'sd2147483648; r.sat = 1'b1;
                end
                yaw_acc = sum;
                roll_h = to_deg(vector_angle(longint'(az) * 256, -longint'(ay) * 256, mag),
                                23040);
                mk = (mag * 39797 + 32768) >>> 16;
                pitch_h = to_deg(vector_angle(mk, longint'(ax) * 256, mag), 11520);
            end else if (cmd == CMD_YAW_RESET) begin
                yaw_acc = 0;
            end
            r.yaw = yaw_acc[31:0]; r.pitch = pitch_h[14:0]; r.roll = roll_h[15:0];
            r.calib = bcount != 0;
            pending.push_back(r);
        endfunction

        function void check_result(t_attitude got);
            t_attitude want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result yaw=%h", got.yaw);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp yaw=%h p=%h r=%h c=%b s=%b got yaw=%h p=%h r=%h c=%b s=%b",
                             want.yaw, want.pitch, want.roll, want.calib, want.sat,
                             got.yaw, got.pitch, got.roll, got.calib, got.sat);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #6 i_clk = ~i_clk;

    iyt_sample_if smp();
    iyt_result_if res();
    iyt_cfg_if    cfg();

    imu_yaw_tilt_estimator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(smp.sink),
        .i_cfg   (cfg.sink),
        .o_result(res.source)
    );

    attitude_board board = new();
    int   cycles;
    logic hold_off;
    logic [31:0] clock_ms;

    initial begin
        smp.valid = 1'b0; smp.command = '0; smp.timestamp_ms = '0; smp.gyro_rate = '0;
        smp.accel_x = '0; smp.accel_y = '0; smp.accel_z = '0;
        cfg.valid = 1'b0; cfg.deadband = '0;
        res.ready = 1'b0;
        hold_off = 1'b0;
        board.clear();
    end

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end
    initial cycles = 0;

    // Receiver: stall on its own pattern, or hold off entirely when asked
    always @(posedge i_clk) begin
        if (hold_off) res.ready <= 1'b0;
        else res.ready <= ($urandom_range(0, 9) < 7) || cycles[9];
        if (res.valid && res.ready)
            board.check_result('{res.yaw_angle, res.pitch_angle, res.roll_angle,
                                 res.calibrating, res.yaw_saturated});
    end

    task automatic send_sample(logic [1:0] cmd, logic [31:0] ts, logic [15:0] g,
                               logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
        smp.valid <= 1'b1; smp.command <= cmd; smp.timestamp_ms <= ts;
        smp.gyro_rate <= g; smp.accel_x <= ax; smp.accel_y <= ay; smp.accel_z <= az;
        do @(posedge i_clk); while (!smp.ready);
        board.note_sample(cmd, ts, g, ax, ay, az);
    endtask

    task automatic pause_sender();
        smp.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge i_clk);
    endtask

    task automatic write_deadband(logic [14:0] v);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        cfg.valid <= 1'b1; cfg.deadband <= v;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        board.db = v;
    endtask

    task automatic random_update(int small_dt);
        logic [15:0] g;
        clock_ms += small_dt ? $urandom_range(0, 40) : $urandom;
        g = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
        send_sample(CMD_UPDATE, clock_ms, g, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic random_phase(int count);
        int left, burst, k;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst && left > 0; i++) begin
                k = $urandom_range(0, 99);
                if (k < 80) random_update(k < 75);
                else if (k < 95) begin
                    clock_ms += $urandom_range(0, 20);
                    send_sample(CMD_CALIB, clock_ms, 16'($urandom_range(0, 300) - 150),
                                16'($urandom), 16'($urandom), 16'($urandom));
                end else send_sample(CMD_YAW_RESET, $urandom, 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom));
                left--;
            end
            if ($urandom_range(0, 3) != 0) pause_sender();
        end
        smp.valid <= 1'b0;
    endtask

    initial begin
        logic [14:0] dbs[5];
        dbs = '{15'd0, 15'd32767, 15'd61, 15'd5, 15'd300};
        clock_ms = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: extremes, zero vector, every named command, time wrap, saturation
        send_sample(CMD_UPDATE, 32'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(CMD_UPDATE, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_sample(CMD_UPDATE, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_sample(CMD_YAW_RESET, 32'd5, 16'h1234, '0, '0, '0);
        send_sample(CMD_UPDATE, 32'h8000_0000, 16'h8000, 16'h0000, 16'h0000, 16'h8000);
        send_sample(CMD_UPDATE, 32'h0000_0010, 16'h8000, 16'h0100, 16'h0000, 16'h0000);
        send_sample(CMD_UPDATE, 32'h0000_0020, 16'd60, 16'hFFFF, 16'h0001, 16'hFFFF);
        send_sample(CMD_UPDATE, 32'h0000_0030, 16'd61, 16'h0000, 16'hFF00, 16'h0100);
        send_sample(CMD_UPDATE, 32'h0000_0040, -16'd61, 16'h8000, 16'h0000, 16'h0000);
        send_sample(CMD_CALIB, 32'h0000_0050, 16'h7FFF, '0, '0, '0);
        send_sample(CMD_UPDATE, 32'h0000_0060, 16'd100, 16'h0000, 16'h0000, 16'h0100);
        send_sample(CMD_CALIB, 32'h0000_0070, 16'h8000, '0, '0, '0);
        // Finish a calibration run with a nonzero mean
        for (int i = 0; i < CALIB_SAMPLES; i++) begin
            clock_ms += 1;
            send_sample(CMD_CALIB, clock_ms, 16'($urandom_range(0, 100) + 10), '0, '0, '0);
            if (i % 97 == 0) pause_sender();
        end
        // Fill the block while the receiver holds off
        hold_off = 1'b1;
        fork
            random_phase(20);
            repeat (400) @(posedge i_clk);
        join_any
        hold_off = 1'b0;
        wait fork;
        for (int p = 0; p < 5; p++) begin
            write_deadband(dbs[p]);
            random_phase(p == 4 ? 200 : 150);
        end
        // Random calibration run, completed after mixed traffic
        for (int i = 0; i < CALIB_SAMPLES; i++) begin
            clock_ms += $urandom_range(0, 3);
            send_sample(CMD_CALIB, clock_ms, 16'($urandom), '0, '0, '0);
        end
        random_phase(30);
        while (board.pending.size() != 0 && cycles < 1400000) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d results over five deadband settings, two calibration runs,",
                 board.checked);
        $display("yaw resets, time wrap, saturation and a long receiver stall.");
        if (board.mismatches == 0 && board.pending.size() == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule

`default_nettype wire
